@@ rtl/htlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants of the linear-probing hash table.
// ----------------------------------------------------------------------------
package htlp_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int KEY_W     = 32;
	localparam int HASH_W    = 32;
	localparam int VAL_W     = 64;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_SET    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_OCC   = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_t;

	// one table entry, kept as a single RAM word
	typedef struct packed {
		slot_t             state;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic idle;
		logic sweep;
		logic probe;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic in_clear;
		logic sweep_last;
		logic probe_done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/htlp_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_intf
// Request and response channels of the hash table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface htlp_req_if;
	logic                           valid;
	logic                           ready;
	logic [htlp_pkg::REQ_W-1:0]     req_type;
	logic [htlp_pkg::KEY_W-1:0]     key_id;
	logic [htlp_pkg::HASH_W-1:0]    key_hash;
	logic [htlp_pkg::VAL_W-1:0]     write_value;

	modport source (output valid, req_type, key_id, key_hash, write_value, input ready);
	modport sink (input valid, req_type, key_id, key_hash, write_value, output ready);
endinterface

interface htlp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [htlp_pkg::STATUS_W-1:0]  status;
	logic                           key_was_new;
	logic [htlp_pkg::VAL_W-1:0]     read_value;

	modport source (output valid, status, key_was_new, read_value, input ready);
	modport sink (input valid, status, key_was_new, read_value, output ready);
endinterface

@@ rtl/htlp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module htlp_ram #(
	parameter int WIDTH = htlp_pkg::ENTRY_W,
	parameter int DEPTH = htlp_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/htlp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_ctrl
// Sequencer: table sweep, probe, finish (write back and result).
// ----------------------------------------------------------------------------
module htlp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  htlp_pkg::sts_t  sts,
	output htlp_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_SWEEP  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_PROBE  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   clr_pend_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = clr_pend_q ? S_FINISH : S_IDLE;
				end
			end
			S_IDLE: begin
				if (sts.in_fire) begin
					state_d = sts.in_clear ? S_SWEEP : S_PROBE;
				end
			end
			S_PROBE: begin
				if (sts.probe_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// reset lands in the sweep so the slot states start out empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			clr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.in_fire && sts.in_clear) begin
				clr_pend_q <= 1'b1;
			end else if (state_q == S_FINISH && sts.out_free) begin
				clr_pend_q <= 1'b0;
			end
		end
	end

	assign cmd.idle   = (state_q == S_IDLE);
	assign cmd.sweep  = (state_q == S_SWEEP);
	assign cmd.probe  = (state_q == S_PROBE);
	assign cmd.finish = (state_q == S_FINISH);

	a_fire_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.in_fire |-> state_q == S_IDLE)
		else $error("request taken outside idle");

	a_clr_pend: assert property (@(posedge clk) disable iff (!arst_n)
		clr_pend_q |-> (state_q == S_SWEEP || state_q == S_FINISH))
		else $error("pending clear outside sweep/finish");

	a_probe_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && sts.probe_done) |=> state_q == S_FINISH)
		else $error("probe end not followed by finish");

endmodule

@@ rtl/htlp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_dpath
// Table RAM, streaming probe evaluation, write back and result register.
// ----------------------------------------------------------------------------
module htlp_dpath #(
	parameter int SLOTS = htlp_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  htlp_pkg::cmd_t  cmd,
	output htlp_pkg::sts_t  sts,
	htlp_req_if.sink        req,
	htlp_rsp_if.source      rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int UW = $clog2(SLOTS + 1);
	localparam logic [UW+1:0] LIMIT = (UW+2)'(3 * SLOTS);

	// latched request
	htlp_pkg::req_t                 req_q;
	logic [htlp_pkg::KEY_W-1:0]     key_q;
	logic [htlp_pkg::VAL_W-1:0]     wval_q;

	// probe stream
	logic [IW-1:0]                  rd_addr_q;
	logic                           rvalid_q;
	logic [IW-1:0]                  idx_s1;
	logic [IW-1:0]                  eval_cnt_q;
	logic                           tomb_seen_q;
	logic [IW-1:0]                  tomb_idx_q;

	// probe outcome
	logic                           found_q;
	logic                           has_slot_q;
	logic                           is_tomb_q;
	logic [IW-1:0]                  res_idx_q;
	logic [htlp_pkg::VAL_W-1:0]     val_q;

	logic [UW-1:0]                  used_q;
	logic [IW-1:0]                  sw_cnt_q;

	logic                           out_valid_q;
	logic [htlp_pkg::STATUS_W-1:0]  out_status_q;
	logic                           out_new_q;
	logic [htlp_pkg::VAL_W-1:0]     out_val_q;

	logic                           accept;
	logic                           out_free;
	logic                           fin;
	logic [htlp_pkg::ENTRY_W-1:0]   ram_rdata;
	htlp_pkg::entry_t               rd_entry;
	htlp_pkg::entry_t               wr_entry;
	htlp_pkg::entry_t               ram_wentry;
	logic                           ram_we;
	logic [IW-1:0]                  ram_addr;

	logic                           cur_hit, cur_empty, cur_tomb;
	logic                           evaluating, last, done;
	logic                           ts_n;
	logic [IW-1:0]                  ti_n;

	logic                           fits;
	logic                           wr_en;
	logic                           inc;
	htlp_pkg::status_t              st;
	logic                           is_new;
	logic [htlp_pkg::VAL_W-1:0]     rval;

	assign accept    = req.valid & cmd.idle;
	assign req.ready = cmd.idle;
	assign out_free  = !out_valid_q | rsp.ready;
	assign fin       = cmd.finish & out_free;

	assign rd_entry = htlp_pkg::entry_t'(ram_rdata);

	// slot evaluation, one returned RAM word per cycle
	assign cur_hit    = (rd_entry.state == htlp_pkg::SLOT_OCC) && (rd_entry.key == key_q);
	assign cur_empty  = (rd_entry.state == htlp_pkg::SLOT_EMPTY);
	assign cur_tomb   = (rd_entry.state == htlp_pkg::SLOT_TOMB);
	assign evaluating = cmd.probe & rvalid_q;
	assign last       = (eval_cnt_q == IW'(SLOTS - 1));
	assign done       = evaluating & (cur_hit | cur_empty | last);
	assign ts_n       = tomb_seen_q | cur_tomb;
	assign ti_n       = tomb_seen_q ? tomb_idx_q : idx_s1;

	// load limit: 4*(used+1) <= 3*SLOTS
	assign fits = {used_q + UW'(1), 2'b00} <= LIMIT;

	always_comb begin
		wr_en    = 1'b0;
		wr_entry = '{state: htlp_pkg::SLOT_OCC, key: key_q, value: wval_q};
		st       = htlp_pkg::ST_DONE;
		is_new   = 1'b0;
		rval     = '0;
		inc      = 1'b0;
		unique case (req_q)
			htlp_pkg::REQ_SET: begin
				if (found_q) begin
					wr_en = 1'b1;
				end else if (has_slot_q && is_tomb_q) begin
					wr_en  = 1'b1;
					is_new = 1'b1;
				end else if (has_slot_q && fits) begin
					wr_en  = 1'b1;
					is_new = 1'b1;
					inc    = 1'b1;
				end else begin
					st = htlp_pkg::ST_FULL;
				end
			end
			htlp_pkg::REQ_GET: begin
				if (found_q) begin
					rval = val_q;
				end else begin
					st = htlp_pkg::ST_NOT_FOUND;
				end
			end
			htlp_pkg::REQ_REMOVE: begin
				if (found_q) begin
					wr_en          = 1'b1;
					wr_entry.state = htlp_pkg::SLOT_TOMB;
				end else begin
					st = htlp_pkg::ST_NOT_FOUND;
				end
			end
			htlp_pkg::REQ_CLEAR: begin
				st = htlp_pkg::ST_DONE;
			end
		endcase
	end

	always_comb begin
		ram_we     = 1'b0;
		ram_addr   = rd_addr_q;
		ram_wentry = wr_entry;
		priority if (cmd.sweep) begin
			ram_we     = 1'b1;
			ram_addr   = sw_cnt_q;
			ram_wentry = '{state: htlp_pkg::SLOT_EMPTY, key: '0, value: '0};
		end else if (cmd.finish) begin
			ram_we   = fin & wr_en;
			ram_addr = res_idx_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	htlp_ram #(
		.WIDTH (htlp_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wentry),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q    <= 1'b0;
			used_q      <= '0;
			sw_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rvalid_q <= 1'b0;
			end else if (cmd.probe) begin
				rvalid_q <= 1'b1;
			end
			if (cmd.sweep) begin
				used_q   <= '0;
				sw_cnt_q <= sw_cnt_q + IW'(1);
			end else if (fin && inc) begin
				used_q <= used_q + UW'(1);
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= htlp_pkg::req_t'(req.req_type);
			key_q       <= req.key_id;
			wval_q      <= req.write_value;
			rd_addr_q   <= req.key_hash[IW-1:0];
			eval_cnt_q  <= '0;
			tomb_seen_q <= 1'b0;
			tomb_idx_q  <= '0;
		end else if (cmd.probe) begin
			rd_addr_q <= rd_addr_q + IW'(1);
			idx_s1    <= rd_addr_q;
			if (evaluating) begin
				eval_cnt_q  <= eval_cnt_q + IW'(1);
				tomb_seen_q <= ts_n;
				tomb_idx_q  <= ti_n;
			end
		end
		if (done) begin
			found_q    <= cur_hit;
			has_slot_q <= cur_hit | cur_empty | ts_n;
			is_tomb_q  <= ts_n;
			res_idx_q  <= (!cur_hit && ts_n) ? ti_n : idx_s1;
			val_q      <= rd_entry.value;
		end
		if (fin) begin
			out_status_q <= st;
			out_new_q    <= is_new;
			out_val_q    <= rval;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.key_was_new = out_new_q;
	assign rsp.read_value  = out_val_q;

	assign sts.in_fire    = accept;
	assign sts.in_clear   = (htlp_pkg::req_t'(req.req_type) == htlp_pkg::REQ_CLEAR);
	assign sts.sweep_last = cmd.sweep & (sw_cnt_q == IW'(SLOTS - 1));
	assign sts.probe_done = done;
	assign sts.out_free   = out_free;

	a_no_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> !ram_we)
		else $error("table written during probe");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{used_q, 2'b00} <= LIMIT)
		else $error("used count beyond load limit");

	a_stream_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !rvalid_q)
		else $error("stale read data after new request");

endmodule

@@ rtl/hash_table_linear_probe_core.sv @@
`timescale 1ns / 1ps
// Flow: a probe from the home slot ends at a hit, an empty or the last slot; finish
// waits for the result register to drain. Clear sweeps every slot instead of probing.
// Throughput: one request at a time, set by the single RAM port that serves the
// probe stream (one slot per cycle) and the write back.
// Reset: asynchronous; afterwards a sweep marks every slot empty with req.ready low.
// ----------------------------------------------------------------------------
// hash_table_linear_probe_core
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_core #(
	parameter int SLOTS = htlp_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	htlp_req_if.sink    req,
	htlp_rsp_if.source  rsp
);

	htlp_pkg::cmd_t cmd;
	htlp_pkg::sts_t sts;

	htlp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	htlp_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ tb/tb_hash_table_linear_probe_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probe_core
// Self-checking bench for the linear-probing hash table. Requests go through
// the valid/ready request channel with random gaps. A table model inside the
// bench predicts status, key_was_new and read_value for every accepted request.
// A monitor compares each response transfer with the oldest prediction. The
// bench runs directed cases first, then the load limit, then random traffic
// over small key pools with clustered hashes.
// ----------------------------------------------------------------------------
module tb_hash_table_linear_probe_core;

	localparam int SLOTS      = htlp_pkg::SLOTS_DEF;
	localparam int IDLE_MAX   = 11;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = SLOTS + 16;

	typedef struct packed {
		htlp_pkg::status_t              status;
		logic                           key_was_new;
		logic [htlp_pkg::VAL_W-1:0]     read_value;
	} rsp_exp_t;

	logic clk;
	logic arst_n;

	htlp_req_if req_ch ();
	htlp_rsp_if rsp_ch ();

	hash_table_linear_probe_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// table model
	logic [htlp_pkg::KEY_W-1:0] tbl_key  [SLOTS];
	logic [htlp_pkg::VAL_W-1:0] tbl_val  [SLOTS];
	bit                         tbl_occ  [SLOTS];
	bit                         tbl_tomb [SLOTS];
	int unsigned                tbl_used;

	rsp_exp_t         expected_rsps[$];
	rsp_exp_t         exp_r;
	int               err_cnt;
	int               quiet_cycles;
	bit               no_idle;

	// random key pool
	logic [htlp_pkg::KEY_W-1:0]  pool_key  [SLOTS];
	logic [htlp_pkg::HASH_W-1:0] pool_hash [SLOTS];
	int                          pool_size;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic rsp_exp_t table_apply(htlp_pkg::req_t op,
	                                         logic [htlp_pkg::KEY_W-1:0] key,
	                                         logic [htlp_pkg::HASH_W-1:0] hash,
	                                         logic [htlp_pkg::VAL_W-1:0] wval);
		rsp_exp_t r;
		bit found;
		bit has_slot;
		bit is_tomb;
		bit tomb_seen;
		int unsigned tomb_idx;
		int unsigned idx;
		int unsigned i;
		bit stop;
		r.status      = htlp_pkg::ST_DONE;
		r.key_was_new = 1'b0;
		r.read_value  = '0;
		if (op == htlp_pkg::REQ_CLEAR) begin
			for (int s = 0; s < SLOTS; s++) begin
				tbl_occ[s]  = 1'b0;
				tbl_tomb[s] = 1'b0;
			end
			tbl_used = 0;
			return r;
		end
		found     = 1'b0;
		has_slot  = 1'b0;
		is_tomb   = 1'b0;
		tomb_seen = 1'b0;
		tomb_idx  = 0;
		idx       = 0;
		stop      = 1'b0;
		i         = hash % SLOTS;
		for (int n = 0; n < SLOTS && !stop; n++) begin
			if (tbl_occ[i]) begin
				if (tbl_key[i] == key) begin
					found = 1'b1;
					idx   = i;
					stop  = 1'b1;
				end
			end else if (tbl_tomb[i]) begin
				if (!tomb_seen) begin
					tomb_seen = 1'b1;
					tomb_idx  = i;
				end
			end else begin
				has_slot = 1'b1;
				is_tomb  = tomb_seen;
				idx      = tomb_seen ? tomb_idx : i;
				stop     = 1'b1;
			end
			i = (i + 1) % SLOTS;
		end
		// probe ran the whole table without an empty slot
		if (!stop && tomb_seen) begin
			has_slot = 1'b1;
			is_tomb  = 1'b1;
			idx      = tomb_idx;
		end
		case (op)
			htlp_pkg::REQ_SET: begin
				if (found) begin
					tbl_val[idx] = wval;
				end else if (has_slot && is_tomb) begin
					tbl_tomb[idx] = 1'b0;
					tbl_occ[idx]  = 1'b1;
					tbl_key[idx]  = key;
					tbl_val[idx]  = wval;
					r.key_was_new = 1'b1;
				end else if (has_slot && 4 * (tbl_used + 1) <= 3 * SLOTS) begin
					tbl_occ[idx]  = 1'b1;
					tbl_key[idx]  = key;
					tbl_val[idx]  = wval;
					tbl_used++;
					r.key_was_new = 1'b1;
				end else begin
					r.status = htlp_pkg::ST_FULL;
				end
			end
			htlp_pkg::REQ_GET: begin
				if (found)
					r.read_value = tbl_val[idx];
				else
					r.status = htlp_pkg::ST_NOT_FOUND;
			end
			default: begin
				if (found) begin
					tbl_occ[idx]  = 1'b0;
					tbl_tomb[idx] = 1'b1;
				end else begin
					r.status = htlp_pkg::ST_NOT_FOUND;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [htlp_pkg::VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return {$urandom(), $urandom()};
	endfunction

	// one request transfer; valid stays high across back-to-back items
	task automatic send_req(htlp_pkg::req_t op, logic [htlp_pkg::KEY_W-1:0] key,
	                        logic [htlp_pkg::HASH_W-1:0] hash,
	                        logic [htlp_pkg::VAL_W-1:0] wval);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= op;
		req_ch.key_id      <= key;
		req_ch.key_hash    <= hash;
		req_ch.write_value <= wval;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_rsps.push_back(table_apply(op, key, hash, wval));
	endtask

	task automatic test_basic_ops();
		send_req(htlp_pkg::REQ_GET, 32'h0, 32'h0, '0);
		send_req(htlp_pkg::REQ_REMOVE, 32'h0, 32'h0, '0);
		send_req(htlp_pkg::REQ_SET, 32'h0, 32'h0, '0);
		send_req(htlp_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		// home slot is the last one, probe wraps past slot 0
		send_req(htlp_pkg::REQ_SET, 32'h5, 32'h0000_003F, 64'hA5A5_5A5A_0F0F_F0F0);
		send_req(htlp_pkg::REQ_GET, 32'h0, 32'h0, '1);
		send_req(htlp_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send_req(htlp_pkg::REQ_GET, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_SET, 32'h5, 32'h0000_003F, 64'h5A5A_A5A5_F0F0_0F0F);
		send_req(htlp_pkg::REQ_GET, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		// probe passes the tombstone to reach the key
		send_req(htlp_pkg::REQ_GET, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_SET, 32'h7, 32'h8000_003F, 64'h1234_5678_9ABC_DEF0);
		send_req(htlp_pkg::REQ_GET, 32'h7, 32'h8000_003F, '0);
		send_req(htlp_pkg::REQ_REMOVE, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_GET, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_REMOVE, 32'h5, 32'h0000_003F, '0);
		send_req(htlp_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		send_req(htlp_pkg::REQ_GET, 32'h0, 32'h0, '0);
		send_req(htlp_pkg::REQ_GET, 32'h7, 32'h8000_003F, '0);
	endtask

	task automatic test_load_limit();
		logic [htlp_pkg::KEY_W-1:0]  victim_key;
		logic [htlp_pkg::HASH_W-1:0] victim_hash;
		send_req(htlp_pkg::REQ_CLEAR, $urandom(), $urandom(), pick_value());
		for (int k = 0; k < SLOTS * 3 / 4 + 2; k++)
			send_req(htlp_pkg::REQ_SET, 32'h1000_0000 + k, $urandom(), pick_value());
		// a found key is never refused, but this set uses a new random hash and may miss it
		send_req(htlp_pkg::REQ_SET, 32'h1000_0003, $urandom(), pick_value());
		victim_key  = 32'h1000_0011;
		victim_hash = 32'hDEAD_0000 | ($urandom() & 32'h3F);
		send_req(htlp_pkg::REQ_REMOVE, victim_key, victim_hash, '0);
		send_req(htlp_pkg::REQ_SET, victim_key, victim_hash, pick_value());
		send_req(htlp_pkg::REQ_SET, 32'h2000_0000, $urandom(), pick_value());
		send_req(htlp_pkg::REQ_CLEAR, $urandom(), $urandom(), pick_value());
	endtask

	task automatic build_pool();
		int sizes[4] = '{6, 20, 40, 56};
		int spread;
		int unsigned base;
		pool_size = sizes[$urandom_range(0, 3)];
		spread    = $urandom_range(1, 16);
		base      = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < pool_size; k++) begin
			pool_key[k]  = $urandom();
			pool_hash[k] = ($urandom() & ~(SLOTS - 1)) |
			               ((base + $urandom_range(0, spread - 1)) % SLOTS);
		end
		pool_key[0] = 32'h0;
		if (pool_size > 1)
			pool_key[1] = 32'hFFFF_FFFF;
	endtask

	task automatic test_random_traffic(int n_items);
		int left;
		int phase_len;
		int sel;
		int k;
		left = n_items;
		while (left > 0) begin
			build_pool();
			no_idle   = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(60, 200);
			if ($urandom_range(0, 1) == 0) begin
				send_req(htlp_pkg::REQ_CLEAR, $urandom(), $urandom(), pick_value());
				left--;
			end
			for (int n = 0; n < phase_len && left > 0; n++) begin
				sel = $urandom_range(0, 99);
				k   = $urandom_range(0, pool_size - 1);
				if (sel < 40)
					send_req(htlp_pkg::REQ_SET, pool_key[k], pool_hash[k], pick_value());
				else if (sel < 70)
					send_req(htlp_pkg::REQ_GET, pool_key[k], pool_hash[k], pick_value());
				else if (sel < 90)
					send_req(htlp_pkg::REQ_REMOVE, pool_key[k], pool_hash[k],
					         pick_value());
				else if (sel < 92)
					send_req(htlp_pkg::REQ_CLEAR, $urandom(), $urandom(), pick_value());
				else if (sel < 96)
					// pool key under a foreign hash
					send_req(htlp_pkg::req_t'($urandom_range(0, 2)), pool_key[k],
					         $urandom(), pick_value());
				else
					send_req(htlp_pkg::req_t'($urandom_range(0, 2)), $urandom(),
					         $urandom(), pick_value());
				left--;
			end
		end
		no_idle = 1'b0;
	endtask

	// response side: random stall before each result
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("result transfer with no request outstanding");
				err_cnt++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, rsp_ch.status);
					err_cnt++;
				end
				if (rsp_ch.key_was_new !== exp_r.key_was_new) begin
					$error("key_was_new: expected %0b, actual %0b", exp_r.key_was_new,
					       rsp_ch.key_was_new);
					err_cnt++;
				end
				if (rsp_ch.read_value !== exp_r.read_value) begin
					$error("read_value: expected %h, actual %h", exp_r.read_value,
					       rsp_ch.read_value);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		err_cnt            = 0;
		quiet_cycles       = 0;
		no_idle            = 1'b0;
		tbl_used           = 0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= htlp_pkg::REQ_SET;
		req_ch.key_id      <= '0;
		req_ch.key_hash    <= '0;
		req_ch.write_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_load_limit();
		test_random_traffic(1270);

		req_ch.valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
